[design/dtcf_pkg.sv]
// ----------------------------------------------------------------------------
// dtcf_pkg
// Shared constants and types for the decimal text to hundredths converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtcf_pkg;

    // Largest whole part accepted
    localparam int WHOLE_LIMIT = 100000000;

    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int WHOLE_W = $clog2(WHOLE_LIMIT + 1);
    // whole * 10 + digit before the limit check
    localparam int PROD_W  = WHOLE_W + 4;
    localparam int FRAC_W  = 7;
    localparam int COUNT_W = 2;
    localparam int HUND_W  = 35;

    // Largest magnitude a good result can carry
    localparam longint HUND_MAX = longint'(WHOLE_LIMIT) * 100 + 100;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    localparam logic [DIGIT_W-1:0] ROUND_DIGIT = 4'd5;

    // Fraction digit counts
    localparam logic [COUNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [COUNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [COUNT_W-1:0] CNT_TWO  = 2'd2;
    localparam logic [COUNT_W-1:0] CNT_SAT  = 2'd3;

    // Final parse state of one text, handed to the output stage
    typedef struct packed {
        logic               ok;
        logic               neg;
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
    } t_snap;

endpackage

`default_nettype wire

[design/dtcf_char_if.sv]
// ----------------------------------------------------------------------------
// dtcf_char_if
// Character request channel: one ASCII character per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dtcf_char_if;
    logic                         valid;
    logic                         ready;
    logic [dtcf_pkg::CHAR_W-1:0]  char_code;
    logic                         carries_char;
    logic                         end_of_text;

    modport source (output valid, char_code, carries_char, end_of_text, input ready);
    modport sink   (input valid, char_code, carries_char, end_of_text, output ready);
endinterface

`default_nettype wire

[design/dtcf_res_if.sv]
// ----------------------------------------------------------------------------
// dtcf_res_if
// Result request channel: parse status and value in hundredths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dtcf_res_if;
    logic                               valid;
    logic                               ready;
    logic                               ok;
    logic signed [dtcf_pkg::HUND_W-1:0] hundredths;

    modport source (output valid, ok, hundredths, input ready);
    modport sink   (input valid, ok, hundredths, output ready);
endinterface

`default_nettype wire

[design/dtcf_scan.sv]
// ----------------------------------------------------------------------------
// dtcf_scan
// Per-character parse state; gives the final state of a text on its last request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtcf_scan (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_take,
    input  wire [dtcf_pkg::CHAR_W-1:0]   i_char,
    input  wire                          i_has,
    input  wire                          i_last,
    output dtcf_pkg::t_snap              o_snap
);

    logic                            r_at_start, n_at_start;
    logic                            r_in_frac,  n_in_frac;
    logic                            r_neg,      n_neg;
    logic [dtcf_pkg::WHOLE_W-1:0]    r_whole,    n_whole;
    logic [dtcf_pkg::FRAC_W-1:0]     r_frac,     n_frac;
    logic [dtcf_pkg::COUNT_W-1:0]    r_count,    n_count;
    logic [dtcf_pkg::DIGIT_W-1:0]    r_third,    n_third;
    logic                            r_seen,     n_seen;
    logic                            r_err,      n_err;

    logic [dtcf_pkg::DIGIT_W-1:0]    digit;
    logic [dtcf_pkg::PROD_W-1:0]     whole_ext;
    logic [dtcf_pkg::PROD_W-1:0]     prod;
    logic [dtcf_pkg::FRAC_W-1:0]     frac_pad;
    logic                            is_digit;

    assign digit     = i_char[dtcf_pkg::DIGIT_W-1:0];
    assign is_digit  = (i_char >= dtcf_pkg::CH_ZERO) && (i_char <= dtcf_pkg::CH_NINE);
    assign whole_ext = {{(dtcf_pkg::PROD_W-dtcf_pkg::WHOLE_W){1'b0}}, r_whole};
    // whole * 10 + digit as shift-add
    assign prod = (whole_ext << 3) + (whole_ext << 1)
                + {{(dtcf_pkg::PROD_W-dtcf_pkg::DIGIT_W){1'b0}}, digit};

    always_comb begin
        n_at_start = r_at_start;
        n_in_frac  = r_in_frac;
        n_neg      = r_neg;
        n_whole    = r_whole;
        n_frac     = r_frac;
        n_count    = r_count;
        n_third    = r_third;
        n_seen     = r_seen;
        n_err      = r_err;

        if (i_has) begin
            n_at_start = 1'b0;
            if (!r_err) begin
                if (r_at_start && (i_char == dtcf_pkg::CH_PLUS
                                   || i_char == dtcf_pkg::CH_MINUS)) begin
                    n_neg = (i_char == dtcf_pkg::CH_MINUS);
                end else if (!r_in_frac && i_char == dtcf_pkg::CH_POINT) begin
                    n_in_frac = 1'b1;
                end else if (!is_digit) begin
                    n_err = 1'b1;
                end else begin
                    n_seen = 1'b1;
                    if (!r_in_frac) begin
                        n_whole = prod[dtcf_pkg::WHOLE_W-1:0];
                        if (prod > dtcf_pkg::PROD_W'(dtcf_pkg::WHOLE_LIMIT)) begin
                            n_err = 1'b1;
                        end
                    end else begin
                        // frac stays below 10 here, so the result fits
                        if (r_count == dtcf_pkg::CNT_NONE || r_count == dtcf_pkg::CNT_ONE) begin
                            n_frac = (r_frac << 3) + (r_frac << 1)
                                   + {{(dtcf_pkg::FRAC_W-dtcf_pkg::DIGIT_W){1'b0}}, digit};
                        end else if (r_count == dtcf_pkg::CNT_TWO) begin
                            n_third = digit;
                        end
                        if (r_count != dtcf_pkg::CNT_SAT) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Pad to two fraction digits, then round on the third
    always_comb begin
        case (n_count)
            dtcf_pkg::CNT_NONE: frac_pad = '0;
            dtcf_pkg::CNT_ONE:  frac_pad = (n_frac << 3) + (n_frac << 1);
            default:            frac_pad = n_frac;
        endcase
    end

    assign o_snap.ok    = !n_err && n_seen;
    assign o_snap.neg   = n_neg;
    assign o_snap.whole = n_whole;
    assign o_snap.frac  = frac_pad + {{(dtcf_pkg::FRAC_W-1){1'b0}},
                                      (n_third >= dtcf_pkg::ROUND_DIGIT)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_in_frac  <= 1'b0;
            r_neg      <= 1'b0;
            r_whole    <= '0;
            r_frac     <= '0;
            r_count    <= dtcf_pkg::CNT_NONE;
            r_third    <= '0;
            r_seen     <= 1'b0;
            r_err      <= 1'b0;
        end else if (i_take) begin
            if (i_last) begin
                r_at_start <= 1'b1;
                r_in_frac  <= 1'b0;
                r_neg      <= 1'b0;
                r_whole    <= '0;
                r_frac     <= '0;
                r_count    <= dtcf_pkg::CNT_NONE;
                r_third    <= '0;
                r_seen     <= 1'b0;
                r_err      <= 1'b0;
            end else begin
                r_at_start <= n_at_start;
                r_in_frac  <= n_in_frac;
                r_neg      <= n_neg;
                r_whole    <= n_whole;
                r_frac     <= n_frac;
                r_count    <= n_count;
                r_third    <= n_third;
                r_seen     <= n_seen;
                r_err      <= n_err;
            end
        end
    end

endmodule

`default_nettype wire

[design/decimal_text_to_centi_fixed.sv]
// ----------------------------------------------------------------------------
// decimal_text_to_centi_fixed
// Streams an ASCII decimal number, one character per request, into a signed
// value in hundredths.
//
// Channels: i_chr takes one request per character (char_code, carries_char,
// end_of_text); o_res returns one request (ok, hundredths) per text, made on
// the request marked end_of_text. A request with carries_char low only ends
// the text or is skipped.
// Throughput: one character per cycle while i_chr.ready is high, texts back to
// back with no gap; the parse state loop (whole * 10 + digit and the limit
// compare) updates on each character taken. Pipeline: when its last character
// is taken, the final parse state of a text enters the snapshot register, then
// passes through the x100 scaling and sign into the output register.
// Reset: synchronous, active low; the parse state returns to the start of a
// text and both result stages empty.
// Stall: when o_res is held off, the snapshot stage keeps filling; once both
// stages are full i_chr.ready falls until the receiver takes a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_to_centi_fixed (
    input  wire          i_clk,
    input  wire          i_rst_n,
    dtcf_char_if.sink    i_chr,
    dtcf_res_if.source   o_res
);

    // Handshake and stage enables
    logic                            take;
    logic                            a_ready;
    logic                            b_ready;

    // Snapshot stage: final parse state of a finished text
    dtcf_pkg::t_snap                 snap;
    logic                            r_a_vld;
    dtcf_pkg::t_snap                 r_a_snap;

    // Output stage
    logic                            r_b_vld;
    logic                            r_b_ok;
    logic [dtcf_pkg::HUND_W-1:0]     r_b_hund, n_b_hund;

    // Scaling datapath
    logic [dtcf_pkg::HUND_W-1:0]     whole_ext;
    logic [dtcf_pkg::HUND_W-1:0]     total;

    // Ready chains back from the receiver through both stages
    assign b_ready     = !r_b_vld || o_res.ready;
    assign a_ready     = !r_a_vld || b_ready;
    assign i_chr.ready = a_ready;
    assign take        = i_chr.valid && a_ready;

    dtcf_scan u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (take),
        .i_char (i_chr.char_code),
        .i_has  (i_chr.carries_char),
        .i_last (i_chr.end_of_text),
        .o_snap (snap)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (a_ready) begin
            r_a_vld <= take && i_chr.end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_snap <= snap;
        end
    end

    // whole * 100 = whole * 64 + whole * 32 + whole * 4, wrapping at 35 bits
    assign whole_ext = {{(dtcf_pkg::HUND_W-dtcf_pkg::WHOLE_W){1'b0}}, r_a_snap.whole};
    assign total     = (whole_ext << 6) + (whole_ext << 5) + (whole_ext << 2)
                     + {{(dtcf_pkg::HUND_W-dtcf_pkg::FRAC_W){1'b0}}, r_a_snap.frac};

    always_comb begin
        if (!r_a_snap.ok) begin
            n_b_hund = '0;
        end else if (r_a_snap.neg) begin
            n_b_hund = '0 - total;
        end else begin
            n_b_hund = total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (b_ready) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready) begin
            r_b_ok   <= r_a_snap.ok;
            r_b_hund <= n_b_hund;
        end
    end

    assign o_res.valid      = r_b_vld;
    assign o_res.ok         = r_b_ok;
    assign o_res.hundredths = r_b_hund;

`ifndef SYNTHESIS
    // A failed parse carries a zero value
    a_fail_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ok) |-> (o_res.hundredths == '0))
        else $error("failed parse with non-zero value");

    // The last character of a text always fills the snapshot stage
    a_last_fills_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_chr.end_of_text) |=> r_a_vld)
        else $error("end of text lost");

    // A good result stays within the whole-part limit
    a_ok_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ok) |->
            (longint'(o_res.hundredths) <= dtcf_pkg::HUND_MAX
             && longint'(o_res.hundredths) >= -dtcf_pkg::HUND_MAX))
        else $error("good result out of range");

    // Stalled output stage holds its result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && !o_res.ready) |=> (r_b_vld && $stable(r_b_hund) && $stable(r_b_ok)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
